// ===== rtl/rhlv_pkg.sv =====
// shared types, codes and constants for the rssi history link verdict block
// no dependencies; the top, datapath and controller files refer to this package by scoped names

package rhlv_pkg;

    // history depth default
    localparam int HISTORY_DEPTH_DEF = 128;

    // field widths
    localparam int SAMPLE_W   = 9;
    localparam int PKT_W      = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int LOSS_W     = 39;

    // opcodes
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_EVAL  = 2'd2;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_SF          = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_SAMPLES = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LOSS_MAX    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_MARGIN_MIN  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_MARGIN_GOOD = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_ASYM_MAX    = 3'd5;

    // register reset values
    localparam logic [3:0]        RST_SF          = 4'd9;
    localparam logic [15:0]       RST_MIN_SAMPLES = 16'd10;
    localparam logic [6:0]        RST_LOSS_MAX    = 7'd10;
    localparam logic signed [7:0] RST_MARGIN_MIN  = 8'sd10;
    localparam logic signed [7:0] RST_MARGIN_GOOD = 8'sd20;
    localparam logic [7:0]        RST_ASYM_MAX    = 8'd10;

    // verdicts
    localparam logic [1:0] VERD_COLLECT  = 2'd0;
    localparam logic [1:0] VERD_REJECT   = 2'd1;
    localparam logic [1:0] VERD_LIMIT    = 2'd2;
    localparam logic [1:0] VERD_APPROVED = 2'd3;

    // reason codes
    localparam logic [2:0] RSN_COLLECT  = 3'd0;
    localparam logic [2:0] RSN_LOSS     = 3'd1;
    localparam logic [2:0] RSN_LOW_MARG = 3'd2;
    localparam logic [2:0] RSN_MARGINAL = 3'd3;
    localparam logic [2:0] RSN_ASYM     = 3'd4;
    localparam logic [2:0] RSN_OK       = 3'd5;

    // sample extremes, seed values of the min and max search
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 9'sh0ff;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 9'sh100;

    // percent scale of the loss test
    localparam logic [6:0] LOSS_SCALE = 7'd100;

    // controller to datapath commands
    typedef struct packed {
        logic push;
        logic clear;
        logic load;
        logic rd_issue;
        logic div_start;
        logic div_step;
        logic mean_load;
        logic commit;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic walk_zero;
        logic walk_last;
        logic div_last;
    } t_dp_status;

    // receiver sensitivity in half-dB by spreading factor
    function automatic logic signed [9:0] sens_half_db(input logic [3:0] sf);
        logic signed [9:0] s;
        unique case (sf)
            4'd7:    s = -10'sd246;
            4'd8:    s = -10'sd252;
            4'd9:    s = -10'sd258;
            4'd10:   s = -10'sd264;
            4'd11:   s = -10'sd269;
            4'd12:   s = -10'sd274;
            default: s = -10'sd258;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/rssi_history_link_verdict.sv =====
// rssi history and link verdict, top level
// push and clear take one beat per cycle; an evaluate holds the input side until done
// an evaluate walks the held samples through the one read port, then divides the sum bit-serially;
// the sum is SUMW = 9 + log2(depth) bits wide (16 at depth 128)
// the next item is accepted the cycle after the result enters the output register
// sync active-low reset: empty history, default registers; sample memory is not cleared

module rssi_history_link_verdict #(
    parameter int HISTORY_DEPTH = rhlv_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_opcode,
    input  logic signed [8:0]               i_sample_dbm,
    input  logic [31:0]                     i_packets_sent,
    input  logic [31:0]                     i_packets_received,
    input  logic signed [8:0]               i_remote_dbm,
    // result channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [1:0]                      o_verdict,
    output logic [2:0]                      o_reason_code,
    output logic [7:0]                      o_sample_count,
    output logic signed [8:0]               o_min_dbm,
    output logic signed [8:0]               o_mean_dbm,
    output logic signed [8:0]               o_max_dbm,
    output logic signed [9:0]               o_margin_db,
    output logic [8:0]                      o_asymmetry_db,
    // register writes
    input  logic                            i_cfg_we,
    input  logic [rhlv_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [rhlv_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    // command and status between sequencer and datapath
    rhlv_pkg::t_dp_cmd    w_cmd;
    rhlv_pkg::t_dp_status w_status;

    // sequencer: takes input beats, steps walk / divide / verdict, owns result valid
    rhlv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_opcode(i_opcode),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (w_cmd),
        .i_status(w_status)
    );

    // datapath: sample ring in ram, running min/max/sum, divider, margin and verdict
    rhlv_datapath #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_sample_dbm      (i_sample_dbm),
        .i_packets_sent    (i_packets_sent),
        .i_packets_received(i_packets_received),
        .i_remote_dbm      (i_remote_dbm),
        .o_verdict         (o_verdict),
        .o_reason_code     (o_reason_code),
        .o_sample_count    (o_sample_count),
        .o_min_dbm         (o_min_dbm),
        .o_mean_dbm        (o_mean_dbm),
        .o_max_dbm         (o_max_dbm),
        .o_margin_db       (o_margin_db),
        .o_asymmetry_db    (o_asymmetry_db)
    );

endmodule

// ===== rtl/rhlv_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies

module rhlv_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 128,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rhlv_datapath.sv =====
// datapath: config registers, sample ring, walk, divider, verdict and result register
// depends on rhlv_pkg and rhlv_ram

module rhlv_datapath #(
    parameter int HISTORY_DEPTH = rhlv_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rhlv_pkg::t_dp_cmd                   i_cmd,
    output rhlv_pkg::t_dp_status                o_status,
    input  logic                                i_cfg_we,
    input  logic [rhlv_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [rhlv_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic signed [8:0]                   i_sample_dbm,
    input  logic [31:0]                         i_packets_sent,
    input  logic [31:0]                         i_packets_received,
    input  logic signed [8:0]                   i_remote_dbm,
    output logic [1:0]                          o_verdict,
    output logic [2:0]                          o_reason_code,
    output logic [7:0]                          o_sample_count,
    output logic signed [8:0]                   o_min_dbm,
    output logic signed [8:0]                   o_mean_dbm,
    output logic signed [8:0]                   o_max_dbm,
    output logic signed [9:0]                   o_margin_db,
    output logic [8:0]                          o_asymmetry_db
);

    localparam int AW   = $clog2(HISTORY_DEPTH);
    localparam int CW   = $clog2(HISTORY_DEPTH + 1);
    localparam int PW   = AW + 1;
    localparam int SUMW = rhlv_pkg::SAMPLE_W + AW;
    localparam int DCW  = $clog2(SUMW + 1);
    localparam int LW   = rhlv_pkg::LOSS_W;

    // config registers
    logic [3:0]        r_sf;
    logic [15:0]       r_min_samples;
    logic [6:0]        r_loss_max;
    logic signed [7:0] r_margin_min;
    logic signed [7:0] r_margin_good;
    logic [7:0]        r_asym_max;

    // history state
    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;

    // evaluate operands
    logic [31:0]       r_sent;
    logic [31:0]       r_recv;
    logic signed [8:0] r_remote;

    // walk
    logic [AW-1:0] r_addr;
    logic [CW-1:0] r_left;
    logic          r_rd_pend;
    logic signed [SUMW-1:0] r_sum;
    logic signed [8:0]      r_mn;
    logic signed [8:0]      r_mx;

    // divider
    logic [SUMW-1:0] r_quo;
    logic [CW-1:0]   r_rem;
    logic            r_neg;
    logic [DCW-1:0]  r_dcnt;

    // loss test
    logic [LW-1:0] r_prod_loss;
    logic [LW-1:0] r_prod_lim;
    logic          r_lossy;
    logic          r_loss;

    logic signed [8:0] r_mean;

    // result register
    logic [1:0]        r_o_verdict;
    logic [2:0]        r_o_reason;
    logic [7:0]        r_o_count;
    logic signed [8:0] r_o_min;
    logic signed [8:0] r_o_mean;
    logic signed [8:0] r_o_max;
    logic signed [9:0] r_o_margin;
    logic [8:0]        r_o_asym;

    logic signed [8:0] w_rd_data;
    logic [8:0]        w_rd_raw;
    logic [PW-1:0]     w_start;
    logic [CW:0]       w_trial;
    logic              w_ge;
    logic [SUMW-1:0]   w_mag;
    logic [9:0]        w_qm;
    logic [9:0]        w_mean_s;
    logic signed [9:0]  w_sens;
    logic signed [10:0] w_x;
    logic signed [10:0] w_xr;
    logic signed [9:0]  w_margin;
    logic signed [9:0]  w_diff;
    logic signed [9:0]  w_absd;
    logic [8:0]         w_asym;
    logic               w_empty;
    logic [1:0]         w_verdict;
    logic [2:0]         w_reason;

    rhlv_ram #(
        .WIDTH(rhlv_pkg::SAMPLE_W),
        .DEPTH(HISTORY_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.push),
        .i_waddr(r_head),
        .i_wdata(i_sample_dbm),
        .i_raddr(r_addr),
        .o_rdata(w_rd_raw)
    );

    assign w_rd_data = $signed(w_rd_raw);

    // oldest held entry, modulo depth
    always_comb begin
        if (PW'(r_head) >= PW'(r_count)) begin
            w_start = PW'(r_head) - PW'(r_count);
        end else begin
            w_start = PW'(r_head) + PW'(HISTORY_DEPTH) - PW'(r_count);
        end
    end

    // one restoring step
    assign w_trial = {r_rem, r_quo[SUMW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_count});
    assign w_mag   = r_sum[SUMW-1] ? SUMW'(-r_sum) : SUMW'(r_sum);

    // quotient magnitude is at most 256, so ten bits carry it
    assign w_qm     = r_quo[9:0];
    assign w_mean_s = r_neg ? (10'd0 - w_qm) : w_qm;

    // margin, half-dB difference halved toward zero
    assign w_sens   = rhlv_pkg::sens_half_db(r_sf);
    assign w_x      = (11'(r_mean) <<< 1) - 11'(w_sens);
    assign w_xr     = w_x + $signed({10'd0, w_x[10]});
    assign w_margin = $signed(w_xr[10:1]);

    assign w_diff = 10'(r_mean) - 10'(r_remote);
    assign w_absd = w_diff[9] ? (10'sd0 - w_diff) : w_diff;
    assign w_asym = w_absd[8:0];

    assign w_empty = (r_count == '0);

    always_comb begin
        if (w_empty || (r_recv < 32'(r_min_samples))) begin
            w_verdict = rhlv_pkg::VERD_COLLECT;
            w_reason  = rhlv_pkg::RSN_COLLECT;
        end else if (r_loss) begin
            w_verdict = rhlv_pkg::VERD_REJECT;
            w_reason  = rhlv_pkg::RSN_LOSS;
        end else if (w_margin < 10'(r_margin_min)) begin
            w_verdict = rhlv_pkg::VERD_REJECT;
            w_reason  = rhlv_pkg::RSN_LOW_MARG;
        end else if (w_margin < 10'(r_margin_good)) begin
            w_verdict = rhlv_pkg::VERD_LIMIT;
            w_reason  = rhlv_pkg::RSN_MARGINAL;
        end else if (w_asym > 9'(r_asym_max)) begin
            w_verdict = rhlv_pkg::VERD_LIMIT;
            w_reason  = rhlv_pkg::RSN_ASYM;
        end else begin
            w_verdict = rhlv_pkg::VERD_APPROVED;
            w_reason  = rhlv_pkg::RSN_OK;
        end
    end

    // config and history control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sf          <= rhlv_pkg::RST_SF;
            r_min_samples <= rhlv_pkg::RST_MIN_SAMPLES;
            r_loss_max    <= rhlv_pkg::RST_LOSS_MAX;
            r_margin_min  <= rhlv_pkg::RST_MARGIN_MIN;
            r_margin_good <= rhlv_pkg::RST_MARGIN_GOOD;
            r_asym_max    <= rhlv_pkg::RST_ASYM_MAX;
            r_head        <= '0;
            r_count       <= '0;
            r_rd_pend     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    rhlv_pkg::CFG_SF:          r_sf          <= i_cfg_wdata[3:0];
                    rhlv_pkg::CFG_MIN_SAMPLES: r_min_samples <= i_cfg_wdata;
                    rhlv_pkg::CFG_LOSS_MAX:    r_loss_max    <= i_cfg_wdata[6:0];
                    rhlv_pkg::CFG_MARGIN_MIN:  r_margin_min  <= $signed(i_cfg_wdata[7:0]);
                    rhlv_pkg::CFG_MARGIN_GOOD: r_margin_good <= $signed(i_cfg_wdata[7:0]);
                    rhlv_pkg::CFG_ASYM_MAX:    r_asym_max    <= i_cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (i_cmd.push) begin
                r_head <= (r_head == AW'(HISTORY_DEPTH - 1)) ? '0 : r_head + 1'b1;
                if (r_count != CW'(HISTORY_DEPTH)) begin
                    r_count <= r_count + 1'b1;
                end
            end else if (i_cmd.clear) begin
                r_head  <= '0;
                r_count <= '0;
            end
            r_rd_pend <= i_cmd.rd_issue;
        end
    end

    // walk, divider and statistics
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sent   <= i_packets_sent;
            r_recv   <= i_packets_received;
            r_remote <= i_remote_dbm;
            r_addr   <= w_start[AW-1:0];
            r_left   <= r_count;
            r_sum    <= '0;
            r_mn     <= rhlv_pkg::SAMPLE_MAX;
            r_mx     <= rhlv_pkg::SAMPLE_MIN;
        end else begin
            if (i_cmd.rd_issue) begin
                r_addr <= (r_addr == AW'(HISTORY_DEPTH - 1)) ? '0 : r_addr + 1'b1;
                r_left <= r_left - 1'b1;
            end
            if (r_rd_pend) begin
                r_sum <= r_sum + SUMW'(w_rd_data);
                if (w_rd_data < r_mn) begin
                    r_mn <= w_rd_data;
                end
                if (w_rd_data > r_mx) begin
                    r_mx <= w_rd_data;
                end
            end
        end

        if (i_cmd.div_start) begin
            r_neg  <= r_sum[SUMW-1];
            r_quo  <= w_mag;
            r_rem  <= '0;
            r_dcnt <= DCW'(SUMW);
        end else if (i_cmd.div_step) begin
            r_rem  <= w_ge ? CW'(w_trial - {1'b0, r_count}) : w_trial[CW-1:0];
            r_quo  <= {r_quo[SUMW-2:0], w_ge};
            r_dcnt <= r_dcnt - 1'b1;
        end

        // loss products, settled long before they are compared
        r_prod_loss <= LW'(r_sent - r_recv) * LW'(rhlv_pkg::LOSS_SCALE);
        r_prod_lim  <= LW'(r_loss_max) * LW'(r_sent);
        r_lossy     <= (r_sent > r_recv);

        if (i_cmd.mean_load) begin
            r_mean <= w_empty ? 9'sd0 : $signed(w_mean_s[8:0]);
            r_loss <= r_lossy && (r_prod_loss > r_prod_lim);
        end

        if (i_cmd.commit) begin
            r_o_verdict <= w_verdict;
            r_o_reason  <= w_reason;
            r_o_count   <= 8'(r_count);
            r_o_min     <= w_empty ? 9'sd0 : r_mn;
            r_o_mean    <= r_mean;
            r_o_max     <= w_empty ? 9'sd0 : r_mx;
            r_o_margin  <= w_empty ? 10'sd0 : w_margin;
            r_o_asym    <= w_empty ? 9'd0 : w_asym;
        end
    end

    assign o_status.walk_zero = (r_left == '0);
    assign o_status.walk_last = (r_left == CW'(1));
    assign o_status.div_last  = (r_dcnt == DCW'(1));

    assign o_verdict      = r_o_verdict;
    assign o_reason_code  = r_o_reason;
    assign o_sample_count = r_o_count;
    assign o_min_dbm      = r_o_min;
    assign o_mean_dbm     = r_o_mean;
    assign o_max_dbm      = r_o_max;
    assign o_margin_db    = r_o_margin;
    assign o_asymmetry_db = r_o_asym;

    // history bounds
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(HISTORY_DEPTH))
        else $error("held count beyond depth");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= AW'(HISTORY_DEPTH - 1))
        else $error("write head beyond depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push && (r_count != CW'(HISTORY_DEPTH))) |=> (r_count == $past(r_count) + 1'b1))
        else $error("push did not grow history");

endmodule

// ===== rtl/rhlv_ctrl.sv =====
// controller: input handshake, evaluate sequencing and output valid
// depends on rhlv_pkg

module rhlv_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_opcode,
    output logic                 o_valid,
    input  logic                 i_ready,
    output rhlv_pkg::t_dp_cmd    o_cmd,
    input  rhlv_pkg::t_dp_status i_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_DIV_INIT,
        S_DIV,
        S_MEAN,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    rhlv_pkg::t_dp_cmd w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_opcode)
                        rhlv_pkg::OP_PUSH:  w_cmd.push = 1'b1;
                        rhlv_pkg::OP_CLEAR: w_cmd.clear = 1'b1;
                        rhlv_pkg::OP_EVAL: begin
                            w_cmd.load = 1'b1;
                            n_state    = S_WALK;
                        end
                        default: ;
                    endcase
                end
            end
            S_WALK: begin
                if (i_status.walk_zero) begin
                    n_state = S_DRAIN;
                end else begin
                    w_cmd.rd_issue = 1'b1;
                    if (i_status.walk_last) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: n_state = S_DIV_INIT;
            S_DIV_INIT: begin
                w_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                w_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_MEAN;
                end
            end
            S_MEAN: begin
                w_cmd.mean_load = 1'b1;
                n_state         = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_ready) begin
                    w_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (w_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_cmd   = w_cmd;

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.push, w_cmd.clear, w_cmd.load, w_cmd.rd_issue,
                  w_cmd.div_start, w_cmd.div_step, w_cmd.mean_load, w_cmd.commit}))
        else $error("more than one datapath command");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> o_valid)
        else $error("committed result not presented");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> (!r_out_valid || i_ready))
        else $error("result overwritten before taken");

    a_no_overread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rd_issue |-> !i_status.walk_zero)
        else $error("read beyond held samples");

endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for rssi_history_link_verdict: directed table, then random traffic
// predicts or types in every result beat and checks it field by field; needs only rhlv_pkg and the rtl
`timescale 1ns / 1ps

module tb_top;

    import rhlv_pkg::*;

    localparam int DEPTH        = HISTORY_DEPTH_DEF;
    localparam int RESET_CYCLES = 11;
    // drain wait after the last owed result, longer than an evaluate over a full history
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 600;
    localparam int WATCHDOG     = 5000;
    localparam int PHASE_ITEMS  = 200;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_A = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_B = 3'd7;

    // sensitivity in half-dB per spreading factor
    localparam int SENS_TAB [16] = '{-258, -258, -258, -258, -258, -258, -258, -246,
                                     -252, -258, -264, -269, -274, -258, -258, -258};

    typedef struct packed {
        logic [1:0]        verdict;
        logic [2:0]        reason;
        logic [7:0]        count;
        logic signed [8:0] mn;
        logic signed [8:0] mean;
        logic signed [8:0] mx;
        logic signed [9:0] margin;
        logic [8:0]        asym;
    } verdict_t;

    typedef struct {
        logic [1:0]        op;
        logic signed [8:0] sample;
        logic [31:0]       sent;
        logic [31:0]       recv;
        logic signed [8:0] remote;
    } beat_t;

    typedef struct {
        beat_t    b;
        int       reps;
        bit       typed;
        verdict_t want;
    } dir_row_t;

    localparam verdict_t NO_WANT = '0;

    // dut signals; the inputs are known from time zero
    logic                  i_clk              = 1'b0;
    logic                  i_rst_n            = 1'b0;
    logic                  i_valid            = 1'b0;
    logic                  o_ready;
    logic [1:0]            i_opcode           = OP_PUSH;
    logic signed [8:0]     i_sample_dbm       = '0;
    logic [31:0]           i_packets_sent     = '0;
    logic [31:0]           i_packets_received = '0;
    logic signed [8:0]     i_remote_dbm       = '0;
    logic                  o_valid;
    logic                  i_ready            = 1'b0;
    logic [1:0]            o_verdict;
    logic [2:0]            o_reason_code;
    logic [7:0]            o_sample_count;
    logic signed [8:0]     o_min_dbm;
    logic signed [8:0]     o_mean_dbm;
    logic signed [8:0]     o_max_dbm;
    logic signed [9:0]     o_margin_db;
    logic [8:0]            o_asymmetry_db;
    logic                  i_cfg_we           = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr         = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata        = '0;

    rssi_history_link_verdict dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_opcode           (i_opcode),
        .i_sample_dbm       (i_sample_dbm),
        .i_packets_sent     (i_packets_sent),
        .i_packets_received (i_packets_received),
        .i_remote_dbm       (i_remote_dbm),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_verdict          (o_verdict),
        .o_reason_code      (o_reason_code),
        .o_sample_count     (o_sample_count),
        .o_min_dbm          (o_min_dbm),
        .o_mean_dbm         (o_mean_dbm),
        .o_max_dbm          (o_max_dbm),
        .o_margin_db        (o_margin_db),
        .o_asymmetry_db     (o_asymmetry_db),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_addr         (i_cfg_addr),
        .i_cfg_wdata        (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // in-bench copy of the history ring and the registers
    // ---------------------------------------------------------------
    logic signed [8:0] hist_mem [DEPTH];
    int                hist_head;
    int                hist_count;
    int                cfg_sf, cfg_min, cfg_loss, cfg_mmin, cfg_mgood, cfg_asym;

    verdict_t verdict_q[$];    // result beats still owed by the dut

    // bookkeeping for the summary and the verdict
    int fault_cnt    = 0;
    int beats_in     = 0;
    int beats_out    = 0;
    int cfg_writes   = 0;
    int verdict_seen [4] = '{0, 0, 0, 0};

    // idle knobs, percent per cycle
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // long receiver hold-off: main bumps a ticket, the receiver serves it
    int hold_tickets = 0;
    int hold_served  = 0;
    int hold_left    = 0;

    function automatic void history_reset();
        hist_head  = 0;
        hist_count = 0;
        cfg_sf     = RST_SF;
        cfg_min    = RST_MIN_SAMPLES;
        cfg_loss   = RST_LOSS_MAX;
        cfg_mmin   = RST_MARGIN_MIN;
        cfg_mgood  = RST_MARGIN_GOOD;
        cfg_asym   = RST_ASYM_MAX;
    endfunction

    // statistics and verdict of one evaluate beat against the held history
    function automatic verdict_t predict_verdict(beat_t b);
        verdict_t          w;
        int                sum, mn, mx, mean, margin, asym, idx, remote;
        longint unsigned   sent, recv;
        sum    = 0;
        mn     = 0;
        mx     = 0;
        mean   = 0;
        margin = 0;
        asym   = 0;
        remote = b.remote;
        sent   = b.sent;
        recv   = b.recv;
        if (hist_count > 0) begin
            mn = 32767;
            mx = -32768;
            for (int i = 0; i < hist_count; i++) begin
                idx = (hist_head + DEPTH - hist_count + i) % DEPTH;
                if (hist_mem[idx] < mn) mn = hist_mem[idx];
                if (hist_mem[idx] > mx) mx = hist_mem[idx];
                sum += hist_mem[idx];
            end
            // int division truncates toward zero
            mean   = sum / hist_count;
            margin = (2 * mean - SENS_TAB[cfg_sf]) / 2;
            asym   = (mean > remote) ? mean - remote : remote - mean;
        end
        if (hist_count == 0 || recv < longint'(cfg_min)) begin
            w.verdict = VERD_COLLECT;
            w.reason  = RSN_COLLECT;
        end else if (sent > recv && 64'd100 * (sent - recv) > longint'(cfg_loss) * sent) begin
            w.verdict = VERD_REJECT;
            w.reason  = RSN_LOSS;
        end else if (margin < cfg_mmin) begin
            w.verdict = VERD_REJECT;
            w.reason  = RSN_LOW_MARG;
        end else if (margin < cfg_mgood) begin
            w.verdict = VERD_LIMIT;
            w.reason  = RSN_MARGINAL;
        end else if (asym > cfg_asym) begin
            w.verdict = VERD_LIMIT;
            w.reason  = RSN_ASYM;
        end else begin
            w.verdict = VERD_APPROVED;
            w.reason  = RSN_OK;
        end
        w.count  = hist_count[7:0];
        w.mn     = mn[8:0];
        w.mean   = mean[8:0];
        w.mx     = mx[8:0];
        w.margin = margin[9:0];
        w.asym   = asym[8:0];
        return w;
    endfunction

    // state update for one accepted input beat
    function automatic void history_apply(beat_t b);
        case (b.op)
            OP_PUSH: begin
                hist_mem[hist_head] = b.sample;
                hist_head = (hist_head + 1) % DEPTH;
                if (hist_count < DEPTH) hist_count++;
            end
            OP_CLEAR: begin
                hist_count = 0;
                hist_head  = 0;
            end
            OP_EVAL: verdict_q.push_back(predict_verdict(b));
            default: ;    // unused opcode leaves everything alone
        endcase
    endfunction

    function automatic beat_t mk_beat(logic [1:0] op, int sample, longint sent, longint recv,
                                      int remote);
        beat_t b;
        b.op     = op;
        b.sample = sample[8:0];
        b.sent   = sent[31:0];
        b.recv   = recv[31:0];
        b.remote = remote[8:0];
        return b;
    endfunction

    function automatic verdict_t mk_want(int v, int r, int cnt, int mn, int mean, int mx,
                                         int margin, int asym);
        verdict_t w;
        w.verdict = v[1:0];
        w.reason  = r[2:0];
        w.count   = cnt[7:0];
        w.mn      = mn[8:0];
        w.mean    = mean[8:0];
        w.mx      = mx[8:0];
        w.margin  = margin[9:0];
        w.asym    = asym[8:0];
        return w;
    endfunction

    function automatic int clamp_dbm(int v);
        if (v < -256) return -256;
        if (v > 255) return 255;
        return v;
    endfunction

    // evaluate beat aimed at the decision boundaries of the current registers
    function automatic beat_t craft_eval(int center);
        longint sent, recv, lost;
        int     remote;
        case ($urandom_range(9))
            0: begin
                sent = $urandom();
                recv = $urandom();
                if ($urandom_range(1)) sent = 64'hFFFF_FFFF - $urandom_range(0, 3);
            end
            1: begin
                sent = $urandom_range(0, 1000) + cfg_min;
                recv = (cfg_min == 0) ? 0 : $urandom_range(0, cfg_min - 1);
            end
            2: begin
                sent = $urandom_range(0, 100000);
                recv = sent + $urandom_range(1, 1000) + cfg_min;
            end
            3: begin
                sent = 0;
                recv = cfg_min + $urandom_range(0, 50);
            end
            default: begin
                // right around the exact loss boundary
                sent = cfg_min + $urandom_range(0, 100000);
                lost = sent * cfg_loss / 100 + $urandom_range(0, 4) - 2;
                if (lost < 0) lost = 0;
                if (lost > sent) lost = sent;
                recv = sent - lost;
            end
        endcase
        if ($urandom_range(9) < 7)
            remote = clamp_dbm(center + $urandom_range(0, 50) - 25);
        else
            remote = $signed(9'($urandom()));
        return mk_beat(OP_EVAL, $urandom(), sent, recv, remote);
    endfunction

    // ---------------------------------------------------------------
    // input side: one beat per call, random gaps before the beat
    // ---------------------------------------------------------------
    task automatic send_beat(beat_t b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid            <= 1'b1;
        i_opcode           <= b.op;
        i_sample_dbm       <= b.sample;
        i_packets_sent     <= b.sent;
        i_packets_received <= b.recv;
        i_remote_dbm       <= b.remote;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        beats_in++;
    endtask

    task automatic issue_beat(beat_t b);
        send_beat(b);
        history_apply(b);
    endtask

    // wait for every owed result, then let a push or an evaluate in flight finish
    task automatic settle();
        i_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // register write; bits above the register width carry random junk
    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, int value, int width);
        int                    mask;
        logic [CFG_DATA_W-1:0] wd;
        mask = (1 << width) - 1;
        wd   = CFG_DATA_W'(($urandom() & ~mask) | (value & mask));
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= wd;
        @(posedge i_clk);
        cfg_writes++;
        case (idx)
            CFG_SF:          cfg_sf    = wd[3:0];
            CFG_MIN_SAMPLES: cfg_min   = wd[15:0];
            CFG_LOSS_MAX:    cfg_loss  = wd[6:0];
            CFG_MARGIN_MIN:  cfg_mmin  = $signed(wd[7:0]);
            CFG_MARGIN_GOOD: cfg_mgood = $signed(wd[7:0]);
            CFG_ASYM_MAX:    cfg_asym  = wd[7:0];
            default: ;    // spare indexes are ignored by the block
        endcase
    endtask

    task automatic write_all(int sf, int mins, int loss, int mmin, int mgood, int asym);
        write_reg(CFG_SF, sf, 4);
        write_reg(CFG_MIN_SAMPLES, mins, 16);
        write_reg(CFG_LOSS_MAX, loss, 7);
        write_reg(CFG_MARGIN_MIN, mmin, 8);
        write_reg(CFG_MARGIN_GOOD, mgood, 8);
        write_reg(CFG_ASYM_MAX, asym, 8);
        // spare index, must change nothing
        write_reg($urandom_range(1) ? CFG_UNUSED_A : CFG_UNUSED_B, $urandom(), 16);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_config();
        int sf, mins, loss, mmin, mgood, asym;
        sf    = ($urandom_range(9) < 7) ? $urandom_range(7, 12) : $urandom_range(0, 15);
        mins  = ($urandom_range(9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 20);
        loss  = ($urandom_range(3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 30);
        mmin  = $urandom_range(0, 50) - 20;
        mgood = mmin + $urandom_range(0, 20);
        asym  = ($urandom_range(9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 30);
        write_all(sf, mins, loss, mmin, mgood, asym);
    endtask

    // ---------------------------------------------------------------
    // random traffic: mostly push runs followed by evaluates, some noise
    // ---------------------------------------------------------------
    task automatic random_traffic(int n);
        int done_cnt, run_len, center, spread;
        done_cnt = 0;
        while (done_cnt < n) begin
            // band of samples near the sensitivity plus the margin thresholds
            center = clamp_dbm(SENS_TAB[cfg_sf] / 2 + (cfg_mmin + cfg_mgood) / 2
                               + $urandom_range(0, 30) - 15);
            case ($urandom_range(2))
                0: spread = 0;
                1: spread = 3;
                default: spread = 12;
            endcase
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12: begin
                    if ($urandom_range(4) == 0) begin
                        issue_beat(mk_beat(OP_CLEAR, $urandom(), $urandom(), $urandom(),
                                           $urandom()));
                        done_cnt++;
                    end
                    // occasional long run to wrap the ring
                    run_len = ($urandom_range(9) == 0) ? $urandom_range(100, 200)
                                                       : $urandom_range(1, 24);
                    repeat (run_len) begin
                        if ($urandom_range(19) == 0)
                            issue_beat(mk_beat(OP_PUSH, $urandom(), $urandom(), $urandom(),
                                               $urandom()));
                        else
                            issue_beat(mk_beat(OP_PUSH, clamp_dbm(center + $urandom_range(0,
                                               2 * spread) - spread), $urandom(), $urandom(),
                                               $urandom()));
                    end
                    done_cnt += run_len;
                    repeat ($urandom_range(1, 3)) begin
                        issue_beat(craft_eval(center));
                        done_cnt++;
                    end
                end
                13, 14, 15: begin
                    issue_beat(craft_eval(center));
                    done_cnt++;
                end
                16, 17: begin
                    // noise: unused opcode, then a full-range push
                    issue_beat(mk_beat(OP_UNUSED, $urandom(), $urandom(), $urandom(),
                                       $urandom()));
                    issue_beat(mk_beat(OP_PUSH, $urandom(), $urandom(), $urandom(),
                                       $urandom()));
                    done_cnt++;
                end
                default: begin
                    // broken sequence: evaluate on an empty or arbitrary history
                    if ($urandom_range(1)) begin
                        issue_beat(mk_beat(OP_CLEAR, $urandom(), $urandom(), $urandom(),
                                           $urandom()));
                        done_cnt++;
                    end
                    issue_beat(mk_beat(OP_EVAL, $urandom(), $urandom(), $urandom(),
                                       $urandom()));
                    done_cnt++;
                end
            endcase
        end
    endtask

    // ---------------------------------------------------------------
    // receiver: random stalls plus a served long hold-off
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_tickets != hold_served) begin
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
            i_ready     <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------------------------------------------------------
    // result checker: each result beat against the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        verdict_t got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got.verdict = o_verdict;
            got.reason  = o_reason_code;
            got.count   = o_sample_count;
            got.mn      = o_min_dbm;
            got.mean    = o_mean_dbm;
            got.mx      = o_max_dbm;
            got.margin  = o_margin_db;
            got.asym    = o_asymmetry_db;
            beats_out++;
            verdict_seen[got.verdict]++;
            if (verdict_q.size() == 0) begin
                $error("result beat with no evaluate outstanding");
                fault_cnt++;
            end else begin
                want = verdict_q.pop_front();
                if (got.verdict != want.verdict) begin
                    $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
                    fault_cnt++;
                end
                if (got.reason != want.reason) begin
                    $error("reason_code: expected %0d, got %0d", want.reason, got.reason);
                    fault_cnt++;
                end
                if (got.count != want.count) begin
                    $error("sample_count: expected %0d, got %0d", want.count, got.count);
                    fault_cnt++;
                end
                if (got.mn != want.mn) begin
                    $error("min_dbm: expected %0d, got %0d", $signed(want.mn), $signed(got.mn));
                    fault_cnt++;
                end
                if (got.mean != want.mean) begin
                    $error("mean_dbm: expected %0d, got %0d", $signed(want.mean),
                           $signed(got.mean));
                    fault_cnt++;
                end
                if (got.mx != want.mx) begin
                    $error("max_dbm: expected %0d, got %0d", $signed(want.mx), $signed(got.mx));
                    fault_cnt++;
                end
                if (got.margin != want.margin) begin
                    $error("margin_db: expected %0d, got %0d", $signed(want.margin),
                           $signed(got.margin));
                    fault_cnt++;
                end
                if (got.asym != want.asym) begin
                    $error("asymmetry_db: expected %0d, got %0d", want.asym, got.asym);
                    fault_cnt++;
                end
            end
        end
    end

    // watchdog: too long without a beat on either channel
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     quiet_cycles, verdict_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // directed table; expected values typed in where obvious (reset registers)
    // ---------------------------------------------------------------
    dir_row_t dir_rows[$];

    function automatic void add_row(logic [1:0] op, int sample, longint sent, longint recv,
                                    int remote, int reps, bit typed, verdict_t want);
        dir_row_t r;
        r.b     = mk_beat(op, sample, sent, recv, remote);
        r.reps  = reps;
        r.typed = typed;
        r.want  = want;
        dir_rows.push_back(r);
    endfunction

    initial begin
        history_reset();

        // empty history right after reset
        add_row(OP_EVAL, 0, 0, 0, 0, 1, 1, mk_want(VERD_COLLECT, RSN_COLLECT, 0, 0, 0, 0, 0, 0));
        // most negative sample, remote at the other end: widest asymmetry
        add_row(OP_PUSH, -256, 0, 0, 0, 1, 0, NO_WANT);
        add_row(OP_EVAL, 0, 0, 0, 255, 1, 1,
                mk_want(VERD_COLLECT, RSN_COLLECT, 1, -256, -256, -256, -127, 511));
        // mean of -256 and 255 truncates toward zero
        add_row(OP_PUSH, 255, 0, 0, 0, 1, 0, NO_WANT);
        add_row(OP_EVAL, 0, 1000, 1000, 0, 1, 1,
                mk_want(VERD_APPROVED, RSN_OK, 2, -256, 0, 255, 129, 0));
        // loss just over, then exactly on the limit
        add_row(OP_EVAL, 0, 1000, 899, 0, 1, 1,
                mk_want(VERD_REJECT, RSN_LOSS, 2, -256, 0, 255, 129, 0));
        add_row(OP_EVAL, 0, 1000, 900, 0, 1, 1,
                mk_want(VERD_APPROVED, RSN_OK, 2, -256, 0, 255, 129, 0));
        // received above sent, and nothing sent: no loss
        add_row(OP_EVAL, 0, 5, 64'hFFFF_FFFF, 0, 1, 1,
                mk_want(VERD_APPROVED, RSN_OK, 2, -256, 0, 255, 129, 0));
        add_row(OP_EVAL, 0, 0, 10, 0, 1, 1,
                mk_want(VERD_APPROVED, RSN_OK, 2, -256, 0, 255, 129, 0));
        // too few received: collecting but stats still reported
        add_row(OP_EVAL, 0, 64'hFFFF_FFFF, 9, 0, 1, 1,
                mk_want(VERD_COLLECT, RSN_COLLECT, 2, -256, 0, 255, 129, 0));
        // unused opcode with all bits set must not touch the history
        add_row(OP_UNUSED, -1, 64'hFFFF_FFFF, 64'hFFFF_FFFF, -1, 1, 0, NO_WANT);
        add_row(OP_EVAL, 0, 1000, 1000, -1, 1, 0, NO_WANT);
        // clear empties the history
        add_row(OP_CLEAR, 0, 0, 0, 0, 1, 0, NO_WANT);
        add_row(OP_EVAL, 0, 1000, 1000, 0, 1, 1,
                mk_want(VERD_COLLECT, RSN_COLLECT, 0, 0, 0, 0, 0, 0));
        // marginal, low and good margin; asymmetry just over and on the limit
        add_row(OP_PUSH, -110, 0, 0, 0, 1, 0, NO_WANT);
        add_row(OP_EVAL, 0, 100, 100, -110, 1, 1,
                mk_want(VERD_LIMIT, RSN_MARGINAL, 1, -110, -110, -110, 19, 0));
        add_row(OP_CLEAR, 0, 0, 0, 0, 1, 0, NO_WANT);
        add_row(OP_PUSH, -125, 0, 0, 0, 1, 0, NO_WANT);
        add_row(OP_EVAL, 0, 100, 100, -125, 1, 1,
                mk_want(VERD_REJECT, RSN_LOW_MARG, 1, -125, -125, -125, 4, 0));
        add_row(OP_CLEAR, 0, 0, 0, 0, 1, 0, NO_WANT);
        add_row(OP_PUSH, -100, 0, 0, 0, 1, 0, NO_WANT);
        add_row(OP_EVAL, 0, 100, 100, -111, 1, 1,
                mk_want(VERD_LIMIT, RSN_ASYM, 1, -100, -100, -100, 29, 11));
        add_row(OP_EVAL, 0, 100, 100, -110, 1, 1,
                mk_want(VERD_APPROVED, RSN_OK, 1, -100, -100, -100, 29, 10));
        // overfill the ring so the oldest samples get overwritten
        add_row(OP_PUSH, -100, 0, 0, 0, 90, 0, NO_WANT);
        add_row(OP_PUSH, -30, 0, 0, 0, 60, 0, NO_WANT);
        add_row(OP_EVAL, 0, 1000, 1000, -70, 1, 0, NO_WANT);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, no idling on either side
        foreach (dir_rows[i]) begin
            repeat (dir_rows[i].reps) begin
                if (dir_rows[i].typed) begin
                    // typed rows are evaluates only, so no state to update
                    send_beat(dir_rows[i].b);
                    verdict_q.push_back(dir_rows[i].want);
                end else begin
                    issue_beat(dir_rows[i].b);
                end
            end
        end

        // random phases: each one changes the registers while idle and the idling pattern
        for (int ph = 1; ph <= 8; ph++) begin
            settle();
            case (ph)
                5: write_all(0, 0, 0, -128, -128, 0);            // every register at its floor
                6: write_all(15, 65535, 127, 127, 127, 255);     // every register at its ceiling
                default: random_config();
            endcase
            case (ph)
                2, 5: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                3, 6: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                4, 8: begin send_idle_pct = 13; recv_stall_pct = 13; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (ph == 7) begin
                // receiver holds off while the sender keeps offering, twice
                hold_tickets <= hold_tickets + 1;
                random_traffic(PHASE_ITEMS / 2);
                hold_tickets <= hold_tickets + 1;
                random_traffic(PHASE_ITEMS / 2);
            end else begin
                random_traffic(PHASE_ITEMS);
            end
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        settle();

        $display("run: %0d input beats, %0d result beats, %0d register writes, 8 random phases",
                 beats_in, beats_out, cfg_writes);
        $display("verdicts seen: collecting %0d, rejected %0d, limit %0d, approved %0d",
                 verdict_seen[0], verdict_seen[1], verdict_seen[2], verdict_seen[3]);
        if (fault_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== rssi_history_link_verdict.f =====
rtl/rhlv_pkg.sv
rtl/rhlv_ram.sv
rtl/rhlv_datapath.sv
rtl/rhlv_ctrl.sv
rtl/rssi_history_link_verdict.sv
bench/tb_top.sv
